>>> rtl/double_ended_queue_with_search_assert.svh
// Assertion macros used by the deque sequencer.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH

// Checked on every rising edge of clk, muted while rst is high.
`define DEQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define DEQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/deqs_pkg.sv
// Shared constants, codes and the result type of the deque.
`default_nettype none
package deqs_pkg;

  localparam int DEFAULT_DEPTH     = 64;
  localparam int DEFAULT_ITEM_BITS = 32;

  localparam int ACTION_BITS = 3;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int POS_BITS    = 6;
  localparam int OCC_BITS    = 7;

  localparam logic [ACTION_BITS-1:0] ACT_PUSH_TAIL = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_PUSH_HEAD = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_POP_TAIL  = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_POP_HEAD  = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_FIND      = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic        [STATUS_BITS-1:0] status;
    logic signed [VALUE_BITS-1:0]  popped;
    logic        [POS_BITS-1:0]    position;
    logic        [OCC_BITS-1:0]    occupancy;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/deqs_ram.sv
// Ring storage: one write port, one read port, registered read data.
`default_nettype none
module deqs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/deqs_skid.sv
// Output register plus a skid entry that holds one further result during a stall.
`default_nettype none
module deqs_skid (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           up_valid,
  input  wire deqs_pkg::res_t up_res,
  output      logic           up_rdy,
  output      logic           down_valid,
  input  wire logic           down_stall,
  output deqs_pkg::res_t      down_res
);
  import deqs_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || !down_stall) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= up_valid;
        if (up_valid) begin
          main_res <= up_res;
        end
      end
    end else if (up_valid && !skid_valid) begin
      skid_res   <= up_res;
      skid_valid <= 1'b1;
    end
  end

  assign up_rdy     = !skid_valid;
  assign down_valid = main_valid;
  assign down_res   = main_res;

endmodule
`default_nettype wire

>>> rtl/deqs_ctrl.sv
// Sequencer: head/count registers, ring address arithmetic and the search walk.
`default_nettype none
`include "double_ended_queue_with_search_assert.svh"
module deqs_ctrl #(
  parameter int DEPTH     = 64,
  parameter int ITEM_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [deqs_pkg::ACTION_BITS-1:0]   action,
  input  wire logic signed [deqs_pkg::VALUE_BITS-1:0] value,
  output      logic                               res_valid,
  output deqs_pkg::res_t                          res,
  input  wire logic                               out_rdy,
  output      logic                               wr_en,
  output      logic [$clog2(DEPTH)-1:0]           wr_addr,
  output      logic [ITEM_BITS-1:0]               wr_data,
  output      logic                               rd_en,
  output      logic [$clog2(DEPTH)-1:0]           rd_addr,
  input  wire logic [ITEM_BITS-1:0]               rd_data_raw
);
  import deqs_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                  state, state_next;
  logic [IW-1:0]               head, head_next;
  logic [CW-1:0]               count, count_next;
  logic [IW-1:0]               scan_addr, scan_next;
  logic [IW-1:0]               chk_off, chk_next;
  logic signed [ITEM_BITS-1:0] key, key_next;
  logic signed [ITEM_BITS-1:0] item;
  logic signed [ITEM_BITS-1:0] rd_data;
  logic                        accept;
  logic                        full;
  logic                        empty;

  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return IW'(sum);
  endfunction

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] a);
    return (a == IW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  // value is sign-extended or truncated to the stored item width
  assign item    = ITEM_BITS'(value);
  assign rd_data = rd_data_raw;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  assign in_stall = !((state == S_IDLE) && out_rdy);
  assign accept   = in_valid && !in_stall;
  assign wr_data  = item;

  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    scan_next     = scan_addr;
    chk_next      = chk_off;
    key_next      = key;
    res_valid     = 1'b0;
    res           = '0;
    wr_en         = 1'b0;
    wr_addr       = head;
    rd_en         = 1'b0;
    rd_addr       = scan_addr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_PUSH_TAIL: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(head, count);
                count_next = count + 1'b1;
              end
            end
            ACT_PUSH_HEAD: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                head_next  = (head == '0) ? IW'(DEPTH - 1) : head - 1'b1;
                wr_en      = 1'b1;
                wr_addr    = head_next;
                count_next = count + 1'b1;
              end
            end
            ACT_POP_TAIL: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
                rd_en      = 1'b1;
                rd_addr    = ring_add(head, count_next);
                state_next = S_POP;
              end
            end
            ACT_POP_HEAD: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                head_next  = ring_inc(head);
                count_next = count - 1'b1;
                state_next = S_POP;
              end
            end
            ACT_FIND: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = ST_NOT_FOUND;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                scan_next  = ring_inc(head);
                chk_next   = '0;
                key_next   = item;
                state_next = S_SCAN;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_valid  = 1'b1;
        res.popped = VALUE_BITS'(rd_data);
        state_next = S_IDLE;
      end
      S_SCAN: begin
        // read of the next offset runs one ahead of the compare
        rd_en     = 1'b1;
        rd_addr   = scan_addr;
        scan_next = ring_inc(scan_addr);
        chk_next  = chk_off + 1'b1;
        if (rd_data == key) begin
          res_valid    = 1'b1;
          res.position = POS_BITS'(chk_off);
          state_next   = S_IDLE;
        end else if (CW'(chk_off) == count - 1'b1) begin
          res_valid  = 1'b1;
          res.status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.occupancy = OCC_BITS'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_next;
    chk_off   <= chk_next;
    key       <= key_next;
  end

  `DEQS_ASSERT(a_res_has_room, res_valid |-> out_rdy, "result issued with no output room")
  `DEQS_ASSERT(a_push_counts, wr_en |=> (count == $past(count) + 1'b1), "push did not count")
  `DEQS_ASSERT(a_pop_answers, (state == S_POP) |-> res_valid, "pop read gave no result")
  `DEQS_ASSERT(a_scan_frozen, (state == S_SCAN) |-> ($stable(count) && $stable(head)),
    "ring moved during search")
  `DEQS_ASSERT(a_scan_bound, (state == S_SCAN) |-> (CW'(chk_off) < count),
    "search offset beyond occupancy")

endmodule
`default_nettype wire

>>> rtl/double_ended_queue_with_search.sv
// Top level of the bounded deque with linear search.
// Input channel: in_valid/in_stall with action and value; a transaction is taken on
//   a rising edge with in_valid high and in_stall low. Output channel: out_valid/
//   out_stall with status, popped, position and occupancy, one result per request.
// From acceptance, each result is registered in the output stage after it is formed:
//   push, pop of an empty queue, find on an empty queue, undefined action: at acceptance.
//   pop: after the registered ring memory read, in the pop state.
//   find: at the match at offset k from the head, or after the last entry on a miss.
// Throughput: pushes every cycle while the output has room; a pop holds the block for
//   its ring read, a find for its whole walk (single read port, one entry a cycle).
// Ring memory: no reset, not cleared; only occupied entries are compared or returned.
// Reset (rst, synchronous) empties the queue at once: head and count to zero.
// When the receiver stalls, the held result stays put and one further result
//   parks in a skid entry; in_stall then rises until the output drains.
`default_nettype none
module double_ended_queue_with_search #(
  parameter int DEPTH     = deqs_pkg::DEFAULT_DEPTH,
  parameter int ITEM_BITS = deqs_pkg::DEFAULT_ITEM_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output      logic                                   in_stall,
  input  wire logic [deqs_pkg::ACTION_BITS-1:0]       action,
  input  wire logic signed [deqs_pkg::VALUE_BITS-1:0] value,
  output      logic                                   out_valid,
  input  wire logic                                   out_stall,
  output      logic [deqs_pkg::STATUS_BITS-1:0]       status,
  output      logic signed [deqs_pkg::VALUE_BITS-1:0] popped,
  output      logic [deqs_pkg::POS_BITS-1:0]          position,
  output      logic [deqs_pkg::OCC_BITS-1:0]          occupancy
);
  import deqs_pkg::*;

  localparam int IW = $clog2(DEPTH);

  // sequencer to output stage
  logic res_valid;
  res_t res;
  logic out_rdy;
  res_t out_res;

  // ring memory ports; a push writes and a pop or find reads only in distinct
  // cycles, so no read ever meets a write to the same entry
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [ITEM_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [ITEM_BITS-1:0] rd_data;

  deqs_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ITEM_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  deqs_ctrl #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .value       (value),
    .res_valid   (res_valid),
    .res         (res),
    .out_rdy     (out_rdy),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data_raw (rd_data)
  );

  deqs_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (res_valid),
    .up_res     (res),
    .up_rdy     (out_rdy),
    .down_valid (out_valid),
    .down_stall (out_stall),
    .down_res   (out_res)
  );

  assign status    = out_res.status;
  assign popped    = out_res.popped;
  assign position  = out_res.position;
  assign occupancy = out_res.occupancy;

endmodule
`default_nettype wire
